>>> src/mesh_packet_dedup_relay_filter_macros.svh
// Assertion macros shared by the relay filter top level.
`ifndef MESH_PACKET_DEDUP_RELAY_FILTER_MACROS_SVH
`define MESH_PACKET_DEDUP_RELAY_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MPDRF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpdrf same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define MPDRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpdrf next-cycle check failed");

`endif

>>> src/mpdrf_pkg.sv
`default_nettype none

package mpdrf_pkg;

   // Field widths fixed by the item formats
   localparam int SRC_W   = 48;
   localparam int PKT_W   = 16;
   localparam int HOP_W   = 8;
   localparam int TIME_W  = 32;
   localparam int SLOT_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TTL_MS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOP_LIMIT = 2'd1;

   // Configuration reset values
   localparam logic [TIME_W-1:0] TTL_MS_RESET    = 32'd30000;
   localparam logic [HOP_W-1:0]  HOP_LIMIT_RESET = 8'd3;

   typedef struct packed {
      logic [SRC_W-1:0]  source_id;
      logic [PKT_W-1:0]  packet_id;
      logic [HOP_W-1:0]  hop_count;
      logic [TIME_W-1:0] time_ms;
   } req_payload_type;

   typedef struct packed {
      logic              is_duplicate;
      logic              relay;
      logic [HOP_W-1:0]  next_hop_count;
      logic [SLOT_W-1:0] slot_written;
   } rsp_payload_type;

   typedef struct packed {
      logic [SRC_W-1:0]  source;
      logic [PKT_W-1:0]  packet;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hit;
      logic last;
      logic out_free;
   } ctrl_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

>>> src/mpdrf_ctrl.sv
`default_nettype none

module mpdrf_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  mpdrf_pkg::ctrl_status_type status,
   output mpdrf_pkg::ctrl_cmd_type    cmd
);
   import mpdrf_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit || status.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> src/mpdrf_datapath.sv
`default_nettype none

module mpdrf_datapath #(
   parameter int TABLE_DEPTH  = 16,
   parameter int SRC_ID_BYTES = 6
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mpdrf_pkg::ctrl_cmd_type                cmd,
   output mpdrf_pkg::ctrl_status_type             status,
   input  mpdrf_pkg::req_payload_type             req_payload,
   input  logic                                   csr_wr_en,
   input  logic [mpdrf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mpdrf_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output mpdrf_pkg::rsp_payload_type             rsp_payload
);
   import mpdrf_pkg::*;

   localparam int IDX_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SRC_BITS = (8 * SRC_ID_BYTES > SRC_W) ? SRC_W : 8 * SRC_ID_BYTES;
   localparam logic [SRC_W-1:0] SRC_MASK = {SRC_W{1'b1}} >> (SRC_W - SRC_BITS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   // Entry store and per-entry valid bits
   entry_type               table_mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  valid_ff;
   logic [TABLE_DEPTH-1:0]  valid_in;

   // Configuration
   logic [TIME_W-1:0]       ttl_ff;
   logic [HOP_W-1:0]        hop_limit_ff;

   // Item under work
   req_payload_type         item_ff;

   // Scan read stage and evaluate stage
   logic [IDX_W-1:0]        rd_idx_ff;
   logic                    rd_done_ff;
   logic [IDX_W-1:0]        eval_idx_ff;
   logic                    eval_vld_ff;
   entry_type               entry_q_ff;

   // Scan results
   logic                    dup_ff;
   logic                    free_found_ff;
   logic [IDX_W-1:0]        free_idx_ff;
   logic                    have_live_ff;
   logic [IDX_W-1:0]        oldest_idx_ff;
   logic [TIME_W-1:0]       max_age_ff;

   // Result register
   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_ff;
   rsp_payload_type         rsp_in;

   logic                    eval_en;
   logic                    entry_set;
   logic [TIME_W-1:0]       age;
   logic                    expired;
   logic                    live;
   logic                    match;
   logic                    issue;
   logic [IDX_W-1:0]        slot;
   logic                    below_max;

   // Evaluate the entry read last cycle
   always_comb begin
      eval_en   = cmd.scan & eval_vld_ff;
      entry_set = valid_ff[eval_idx_ff];
      age       = item_ff.time_ms - entry_q_ff.stamp;
      expired   = age > ttl_ff;
      live      = entry_set & ~expired;
      match     = live && (entry_q_ff.packet == item_ff.packet_id)
                       && (entry_q_ff.source == item_ff.source_id);
      issue     = cmd.scan & ~rd_done_ff;
      slot      = free_found_ff ? free_idx_ff : oldest_idx_ff;
      below_max = item_ff.hop_count < hop_limit_ff;
   end

   assign status.hit      = eval_en & match;
   assign status.last     = eval_en & (eval_idx_ff == LAST_IDX);
   assign status.out_free = ~rsp_valid_ff | ~rsp_stall;

   // Configuration writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff       <= TTL_MS_RESET;
         hop_limit_ff <= HOP_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TTL_MS:    ttl_ff       <= csr_wdata[TIME_W-1:0];
            CSR_HOP_LIMIT: hop_limit_ff <= csr_wdata[HOP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Capture the item, masking the source to its configured byte count
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= '{source_id: req_payload.source_id & SRC_MASK,
                      packet_id: req_payload.packet_id,
                      hop_count: req_payload.hop_count,
                      time_ms:   req_payload.time_ms};
      end
   end

   // Issue one table read per scan cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff   <= '0;
         rd_done_ff  <= 1'b0;
         eval_vld_ff <= 1'b0;
      end else if (cmd.load) begin
         rd_idx_ff   <= '0;
         rd_done_ff  <= 1'b0;
         eval_vld_ff <= 1'b0;
      end else begin
         eval_vld_ff <= issue & ~status.hit;
         if (issue) begin
            rd_idx_ff <= rd_idx_ff + IDX_W'(1);
            if (rd_idx_ff == LAST_IDX) begin
               rd_done_ff <= 1'b1;
            end
         end
      end
   end

   // Table read port and write port
   always_ff @(posedge clock) begin
      if (issue) begin
         entry_q_ff  <= table_mem[rd_idx_ff];
         eval_idx_ff <= rd_idx_ff;
      end
      if (cmd.commit && !dup_ff) begin
         table_mem[slot] <= '{source: item_ff.source_id,
                              packet: item_ff.packet_id,
                              stamp:  item_ff.time_ms};
      end
   end

   // Drop expired entries as the scan passes; mark the written slot
   always_comb begin
      valid_in = valid_ff;
      if (cmd.commit && !dup_ff) begin
         valid_in[slot] = 1'b1;
      end else if (eval_en && entry_set && expired) begin
         valid_in[eval_idx_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Track duplicate, first free slot and oldest live entry
   always_ff @(posedge clock) begin
      if (reset) begin
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         have_live_ff  <= 1'b0;
      end else if (cmd.load) begin
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         have_live_ff  <= 1'b0;
      end else if (eval_en) begin
         if (match) begin
            dup_ff <= 1'b1;
         end else if (!free_found_ff) begin
            if (!live) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= eval_idx_ff;
            end else if (!have_live_ff || age > max_age_ff) begin
               have_live_ff  <= 1'b1;
               oldest_idx_ff <= eval_idx_ff;
               max_age_ff    <= age;
            end
         end
      end
   end

   // Build the result item
   always_comb begin
      rsp_in.is_duplicate   = dup_ff;
      rsp_in.relay          = ~dup_ff & below_max;
      rsp_in.next_hop_count = (~dup_ff & below_max) ? item_ff.hop_count + HOP_W'(1)
                                                    : item_ff.hop_count;
      rsp_in.slot_written   = dup_ff ? '0 : SLOT_W'(slot);
   end

   // Result register: load on commit, release when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

>>> src/mesh_packet_dedup_relay_filter.sv
// Flow: an item is accepted, the table is scanned, and the result is committed to the result register;
// a duplicate returns earlier, as soon as the scan reaches the matching slot.
// A new item is not accepted until the last one is committed; the scan reads one entry per cycle
// through the single registered read port, and the commit waits for the result register to be free.
// Reset (synchronous, active high) clears all valid bits, restores ttl_ms=30000 and
// the hop limit of 3, and empties the result register; no clearing pass is needed.
`default_nettype none

`include "mesh_packet_dedup_relay_filter_macros.svh"

module mesh_packet_dedup_relay_filter #(
   parameter int TABLE_DEPTH  = 16,
   parameter int SRC_ID_BYTES = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  mpdrf_pkg::req_payload_type        req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mpdrf_pkg::rsp_payload_type        rsp_payload,
   input  logic                              csr_wr_en,
   input  logic [mpdrf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mpdrf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mpdrf_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   mpdrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mpdrf_datapath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .SRC_ID_BYTES (SRC_ID_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // Block stays busy after taking an item
   `MPDRF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // A commit always presents a result next cycle
   `MPDRF_ASSERT_NEXT(a_commit_shows_result, clock, reset, cmd.commit, rsp_valid)
   // A dropped duplicate is never relayed and names no slot
   `MPDRF_ASSERT_NOW(a_dup_no_relay, clock, reset, rsp_valid && rsp_payload.is_duplicate, !rsp_payload.relay && rsp_payload.slot_written == '0)
   // Controller issues at most one command at a time
   `MPDRF_ASSERT_NOW(a_one_cmd, clock, reset, 1'b1, $onehot0({cmd.load, cmd.scan, cmd.commit}))

endmodule

`default_nettype wire
